FILE: rtl/core/swf_pkg.sv
// ----------------------------------------------------------------------------
// swf_pkg
// Shared types and constants of the skin weight fixer: slot count, field
// widths, the vertex record and the merge result passed to compaction.
// ----------------------------------------------------------------------------
package swf_pkg;

  localparam int SLOTS    = 4;
  localparam int BONE_W   = 11;
  localparam int WT_W     = 8;
  localparam int FIELDS_W = SLOTS * BONE_W + SLOTS * WT_W;
  localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
  localparam int PAD_W    = TDATA_W - FIELDS_W;

  typedef logic signed [BONE_W-1:0] bone_t;
  typedef logic [WT_W-1:0]          weight_t;

  localparam bone_t   BONE_NONE  = '1;
  localparam weight_t WEIGHT_MAX = '1;

  typedef struct packed {
    bone_t   [SLOTS-1:0] bone;
    weight_t [SLOTS-1:0] wt;
  } vertex_t;

  typedef struct packed {
    vertex_t vtx;
    logic    fixed;
  } merge_res_t;

endpackage

FILE: rtl/core/swf_merge.sv
// ----------------------------------------------------------------------------
// swf_merge
// Scan of the four slots up to the first negative bone: flag zero weights and
// fold each repeated bone into its latest slot with a saturating add.
// ----------------------------------------------------------------------------
module swf_merge
  import swf_pkg::*;
(
  input  vertex_t    vtx,
  output merge_res_t res
);

  always_comb begin
    logic              stop;
    logic [WT_W:0]     sum;
    weight_t [SLOTS-1:0] wt;
    logic              fixed;
    wt    = vtx.wt;
    fixed = 1'b0;
    stop  = 1'b0;
    sum   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (vtx.bone[i][BONE_W-1]) begin
        stop = 1'b1;
      end
      if (!stop) begin
        if (vtx.wt[i] == '0) begin
          fixed = 1'b1;
        end else begin
          for (int k = 0; k < i; k++) begin
            if (vtx.bone[k] == vtx.bone[i]) begin
              sum   = {1'b0, wt[i]} + {1'b0, wt[k]};
              wt[i] = sum[WT_W] ? WEIGHT_MAX : sum[WT_W-1:0];
              wt[k] = '0;
              fixed = 1'b1;
            end
          end
        end
      end
    end
    res.vtx.bone = vtx.bone;
    res.vtx.wt   = wt;
    res.fixed    = fixed;
  end

endmodule

FILE: rtl/core/swf_compact.sv
// ----------------------------------------------------------------------------
// swf_compact
// Removal of zero-weight slots on a fixed vertex: surviving slots move down in
// order, vacated tail slots get bone -1 and weight 0.
// ----------------------------------------------------------------------------
module swf_compact
  import swf_pkg::*;
(
  input  merge_res_t mrg,
  output vertex_t    vtx
);

  localparam int POS_W = $clog2(SLOTS + 1);
  localparam int IDX_W = $clog2(SLOTS);

  always_comb begin
    logic [POS_W-1:0] pos;
    pos = '0;
    if (!mrg.fixed) begin
      vtx = mrg.vtx;
    end else begin
      for (int j = 0; j < SLOTS; j++) begin
        vtx.bone[j] = BONE_NONE;
        vtx.wt[j]   = '0;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (mrg.vtx.wt[i] != '0) begin
          vtx.bone[pos[IDX_W-1:0]] = mrg.vtx.bone[i];
          vtx.wt[pos[IDX_W-1:0]]   = mrg.vtx.wt[i];
          pos = pos + 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/skin_weight_fixer_top.sv
// ----------------------------------------------------------------------------
// skin_weight_fixer_top
// Cleans the four bone influences of one skinned vertex per transaction.
// ----------------------------------------------------------------------------
// Each vertex passes through an input register that feeds the merge and
// compaction logic, whose result lands in the output register. Throughput
// is one vertex per clock while m_tready stays high; a stalled output holds
// its result and the input register still takes one more vertex. Duplicate
// bones are merged with weights saturated at 255, and on a fixed vertex
// zero-weight slots are dropped and the tail is filled with bone -1, weight
// 0; m_tuser flags such a rewrite.
// ----------------------------------------------------------------------------
module skin_weight_fixer_top
  import swf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // bone_a[10:0], bone_b[21:11], bone_c[32:22], bone_d[43:33], weights[75:44]
  input  logic [TDATA_W-1:0] s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  // bone_a[10:0], bone_b[21:11], bone_c[32:22], bone_d[43:33], weights[75:44]
  output logic [TDATA_W-1:0] m_tdata,
  // was_fixed[0]
  output logic               m_tuser
);

  logic       s1_valid;
  vertex_t    s1_vtx;
  vertex_t    in_vtx;
  merge_res_t mrg;
  vertex_t    cmp_vtx;
  vertex_t    res_vtx;
  logic       res_fixed;
  logic       s2_ready;
  logic       s1_load;
  logic       s2_load;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      in_vtx.bone[i] = s_tdata[i*BONE_W +: BONE_W];
      in_vtx.wt[i]   = s_tdata[SLOTS*BONE_W + i*WT_W +: WT_W];
    end
  end

  assign s2_ready = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s2_ready;
  assign s1_load  = s_tvalid && s_tready;
  assign s2_load  = s1_valid && s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_vtx <= in_vtx;
    end
  end

  swf_merge u_merge (
    .vtx (s1_vtx),
    .res (mrg)
  );

  swf_compact u_compact (
    .mrg (mrg),
    .vtx (cmp_vtx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_ready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      res_vtx   <= cmp_vtx;
      res_fixed <= mrg.fixed;
    end
  end

  always_comb begin
    m_tdata = '0;
    for (int i = 0; i < SLOTS; i++) begin
      m_tdata[i*BONE_W +: BONE_W]            = res_vtx.bone[i];
      m_tdata[SLOTS*BONE_W + i*WT_W +: WT_W] = res_vtx.wt[i];
    end
  end

  assign m_tuser = res_fixed;

  a_clean_passthrough: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !mrg.fixed |-> cmp_vtx == s1_vtx)
    else $error("unfixed vertex altered by compaction");

  a_lead_zero_tail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_fixed && res_vtx.wt[0] == '0 |->
      res_vtx.wt[1] == '0 && res_vtx.wt[2] == '0 && res_vtx.wt[3] == '0)
    else $error("zero weight left ahead of a live slot");

  a_tail_bone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_fixed && res_vtx.wt[SLOTS-1] == '0 |->
      res_vtx.bone[SLOTS-1] == BONE_NONE)
    else $error("vacated tail slot carries a bone");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s1_valid))
    else $error("result issued without a held vertex");

endmodule
